/* design/bmpd_pkg.sv */
// Shared types, codes and helpers for the BMP stream decoder.
// Used by every module of the decoder; depends on nothing else.
`default_nettype none

package bmpd_pkg;

  localparam int PAL_ENTRIES_DFLT = 256;
  localparam int DIM_BITS_DFLT    = 16;
  // Header byte position and palette entry index share one counter.
  localparam int IDX_W            = 9;
  localparam int OQ_DEPTH         = 4;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT_SIG = 3'd1;
  localparam logic [2:0] ST_FORMAT    = 3'd2;
  localparam logic [2:0] ST_DEPTH     = 3'd3;
  localparam logic [2:0] ST_PIXELS    = 3'd4;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [2:0]  status;
    logic        last_of_file;
  } result_t;

  typedef enum logic [4:0] {
    PH_HDR   = 5'b00001,
    PH_PAL   = 5'b00010,
    PH_PIX   = 5'b00100,
    PH_PAD   = 5'b01000,
    PH_AFTER = 5'b10000
  } phase_t;

  // One byte lane write into the palette: lane 0 blue, 1 green, 2 red.
  typedef struct packed {
    logic       en;
    logic [1:0] lane;
    logic [7:0] data;
  } pal_wr_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t mk_pixel(input logic [15:0] x, input logic [15:0] y,
                                       input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    result_t res;
    res.result_kind  = KIND_PIXEL;
    res.pixel_x      = x;
    res.pixel_y      = y;
    res.red          = r;
    res.green        = g;
    res.blue         = b;
    res.status       = ST_OK;
    res.last_of_file = 1'b0;
    return res;
  endfunction

  function automatic result_t mk_end(input logic [1:0] kind, input logic [2:0] st);
    result_t res;
    res              = '0;
    res.result_kind  = kind;
    res.status       = st;
    res.last_of_file = 1'b1;
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/bmpd_palette.sv */
// Palette memory with per-entry valid bits and a read-after-write bypass.
// Depends on bmpd_pkg for the write command type.
`default_nettype none

module bmpd_palette import bmpd_pkg::*; #(
  parameter int ENTRIES = PAL_ENTRIES_DFLT,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [7:0]    rd_byte,
  input  wire pal_wr_t       wr,
  input  wire logic [AW-1:0] wr_addr,
  output logic      [23:0]   rd_color
);

  logic [23:0]        mem_r [ENTRIES];
  logic [ENTRIES-1:0] vld_r;

  logic [AW-1:0] rd_addr;
  logic          rd_ok;

  logic [23:0] rdq_r;
  logic        vldq_r;
  logic        okq_r;
  logic        fwd_r;
  logic [1:0]  fwd_lane_r;
  logic [7:0]  fwd_data_r;
  logic [23:0] base;

  assign rd_addr = rd_byte[AW-1:0];
  assign rd_ok   = {1'b0, rd_byte} < 9'(ENTRIES);

  // A write to an entry that is not yet valid clears its other lanes.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (wr.en && (wr.lane == 2'(l) || !vld_r[wr_addr])) begin
        mem_r[wr_addr][8*l +: 8] <= (wr.lane == 2'(l)) ? wr.data : 8'h00;
      end
    end
    if (rd_en) begin
      rdq_r      <= mem_r[rd_addr];
      vldq_r     <= vld_r[rd_addr];
      okq_r      <= rd_ok;
      fwd_r      <= wr.en && (wr_addr == rd_addr);
      fwd_lane_r <= wr.lane;
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // The read that shares an edge with a write sees the old word; merge the new lane.
  always_comb begin
    base = vldq_r ? rdq_r : 24'h000000;
    if (fwd_r) begin
      case (fwd_lane_r)
        2'd0:    base[7:0]   = fwd_data_r;
        2'd1:    base[15:8]  = fwd_data_r;
        2'd2:    base[23:16] = fwd_data_r;
        default: base        = base;
      endcase
    end
    rd_color = okq_r ? base : 24'h000000;
  end

endmodule

`default_nettype wire

/* design/bmpd_parser.sv */
// Input register and per-byte decode: header fields, palette load, pixels and padding.
// Depends on bmpd_pkg; drives palette writes and pushes results to the output queue.
`default_nettype none

module bmpd_parser import bmpd_pkg::*; #(
  parameter int ENTRIES  = PAL_ENTRIES_DFLT,
  parameter int DIM_BITS = DIM_BITS_DFLT,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire in_item_t      in_data,
  input  wire logic          space_ok,
  output logic               s0_valid,
  input  wire logic [23:0]   pal_color,
  output pal_wr_t            pal_wr,
  output logic [AW-1:0]      pal_wr_addr,
  output push_t              push
);

  localparam logic [31:0] DIM_MAX   = 32'((64'd1 << DIM_BITS) - 64'd1);
  localparam logic [31:0] ENT32     = 32'(ENTRIES);
  localparam logic [IDX_W-1:0] ENT_IDX    = IDX_W'(ENTRIES);
  localparam logic [IDX_W-1:0] COLORS_8B  = IDX_W'(256);
  localparam logic             DFLT_OVER  = (256 > ENTRIES);
  localparam logic [15:0] SIGNATURE  = 16'h4d42;
  localparam logic [31:0] HSIZE_CORE = 32'd12;
  localparam logic [31:0] HSIZE_INFO = 32'd40;

  localparam logic [IDX_W-1:0] P_SIG     = IDX_W'(1);
  localparam logic [IDX_W-1:0] P_HSIZE   = IDX_W'(17);
  localparam logic [IDX_W-1:0] CORE_WID  = IDX_W'(19);
  localparam logic [IDX_W-1:0] CORE_HGT  = IDX_W'(21);
  localparam logic [IDX_W-1:0] CORE_BPP  = IDX_W'(25);
  localparam logic [IDX_W-1:0] INFO_WID  = IDX_W'(21);
  localparam logic [IDX_W-1:0] INFO_HGT  = IDX_W'(25);
  localparam logic [IDX_W-1:0] INFO_BPP  = IDX_W'(29);
  localparam logic [IDX_W-1:0] INFO_COMP = IDX_W'(33);
  localparam logic [IDX_W-1:0] INFO_CLR  = IDX_W'(49);
  localparam logic [IDX_W-1:0] INFO_END  = IDX_W'(53);

  logic          s0_valid_r, s0_valid_nxt;
  in_item_t      s0_data_r;

  phase_t              phase_r, phase_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [31:0]         asm_r, asm_nxt;
  logic [1:0]          comp_r, comp_nxt;
  logic [1:0]          fbc_r, fbc_nxt;
  logic                core_r, core_nxt;
  logic                bpp8_r, bpp8_nxt;
  logic                bpp24_r, bpp24_nxt;
  logic [DIM_BITS-1:0] wid_lo_r, wid_lo_nxt;
  logic                wid_big_r, wid_big_nxt;
  logic [DIM_BITS-1:0] hgt_lo_r, hgt_lo_nxt;
  logic                hgt_big_r, hgt_big_nxt;
  logic                comp_nz_r, comp_nz_nxt;
  logic                clr_zero_r, clr_zero_nxt;
  logic                clr_big_r, clr_big_nxt;
  logic [IDX_W-1:0]    clr_lo_r, clr_lo_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [IDX_W-1:0]    ccnt_r, ccnt_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  logic [1:0]          pad_r, pad_nxt;
  logic [15:0]         part_r, part_nxt;

  logic                proc;
  logic [7:0]          b;
  logic [31:0]         asm_new;
  logic [15:0]         w16;
  logic [31:0]         hv;
  logic [IDX_W-1:0]    p_wid, p_hgt, p_bpp, p_end;
  logic                bpp8_e, bpp24_e;
  logic                colors_dflt;
  logic [IDX_W-1:0]    colors;
  logic                colors_over;
  logic [DIM_BITS-1:0] sp_w, sp_h;
  logic [DIM_BITS:0]   col_inc;
  logic                row_end;
  logic [1:0]          pad_new;
  logic [1:0]          pad_dec;
  logic [7:0]          px_r, px_g, px_b;
  logic [IDX_W-1:0]    pos_inc;

  logic                do_fail, do_sp, do_emit, do_end_row, do_hdr_start;
  logic [2:0]          fail_st;
  result_t             fin;

  assign s0_valid = s0_valid_r;
  assign proc     = s0_valid_r & space_ok;
  assign b        = s0_data_r.byte_value;
  assign asm_new  = {b, asm_r[31:8]};
  assign w16      = asm_new[31:16];
  assign hv       = core_r ? {16'h0000, w16} : asm_new;
  assign p_wid    = core_r ? CORE_WID : INFO_WID;
  assign p_hgt    = core_r ? CORE_HGT : INFO_HGT;
  assign p_bpp    = core_r ? CORE_BPP : INFO_BPP;
  assign p_end    = core_r ? CORE_BPP : INFO_END;
  // A core header ends on the byte that completes its depth field.
  assign bpp8_e   = core_r ? (w16 == 16'd8)  : bpp8_r;
  assign bpp24_e  = core_r ? (w16 == 16'd24) : bpp24_r;

  assign colors_dflt = core_r | clr_zero_r;
  assign colors      = colors_dflt ? (bpp8_e ? COLORS_8B : '0) : clr_lo_r;
  assign colors_over = colors_dflt ? (bpp8_e & DFLT_OVER) : clr_big_r;

  assign sp_w = (phase_r == PH_PAL) ? width_r  : wid_lo_r;
  assign sp_h = (phase_r == PH_PAL) ? height_r : hgt_lo_r;

  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_end = col_inc >= {1'b0, width_r};
  // Row bytes are width or three times width; padding rounds them up to four.
  assign pad_new = bpp8_r ? 2'(2'd0 - width_r[1:0]) : width_r[1:0];
  assign pad_dec = pad_r - 2'd1;
  assign pos_inc = pos_r + 1'b1;

  assign px_r = bpp8_r ? pal_color[23:16] : b;
  assign px_g = bpp8_r ? pal_color[15:8]  : part_r[15:8];
  assign px_b = bpp8_r ? pal_color[7:0]   : part_r[7:0];

  assign pal_wr.en   = proc && !s0_data_r.end_of_stream && (phase_r == PH_PAL) &&
                       (comp_r != 2'd3) && (pos_r < ENT_IDX);
  assign pal_wr.lane = comp_r;
  assign pal_wr.data = b;
  assign pal_wr_addr = pos_r[AW-1:0];

  always_comb begin
    s0_valid_nxt = accept ? 1'b1 : (proc ? 1'b0 : s0_valid_r);

    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    asm_nxt      = asm_r;
    comp_nxt     = comp_r;
    fbc_nxt      = fbc_r;
    core_nxt     = core_r;
    bpp8_nxt     = bpp8_r;
    bpp24_nxt    = bpp24_r;
    wid_lo_nxt   = wid_lo_r;
    wid_big_nxt  = wid_big_r;
    hgt_lo_nxt   = hgt_lo_r;
    hgt_big_nxt  = hgt_big_r;
    comp_nz_nxt  = comp_nz_r;
    clr_zero_nxt = clr_zero_r;
    clr_big_nxt  = clr_big_r;
    clr_lo_nxt   = clr_lo_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    ccnt_nxt     = ccnt_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pad_nxt      = pad_r;
    part_nxt     = part_r;

    do_fail      = 1'b0;
    fail_st      = ST_OK;
    do_sp        = 1'b0;
    do_emit      = 1'b0;
    do_end_row   = 1'b0;
    do_hdr_start = 1'b0;
    fin          = mk_end(KIND_FINISH, ST_OK);
    push         = '0;

    if (proc) begin
      if (s0_data_r.end_of_stream) begin
        do_hdr_start = 1'b1;
        if (phase_r != PH_AFTER) begin
          do_fail = 1'b1;
          if (phase_r == PH_HDR) begin
            fail_st = (pos_r < IDX_W'(2)) ? ST_SHORT_SIG : ST_FORMAT;
          end else if (phase_r == PH_PAL) begin
            fail_st = ST_FORMAT;
          end else begin
            fail_st = ST_PIXELS;
          end
        end
      end else begin
        unique case (phase_r)
          PH_HDR: begin
            asm_nxt = asm_new;
            pos_nxt = pos_inc;
            if (pos_r == P_SIG && w16 != SIGNATURE) begin
              do_fail = 1'b1;
              fail_st = ST_FORMAT;
            end else if (pos_r == P_HSIZE) begin
              if (asm_new == HSIZE_CORE || asm_new == HSIZE_INFO) begin
                core_nxt     = (asm_new == HSIZE_CORE);
                comp_nz_nxt  = 1'b0;
                clr_zero_nxt = 1'b1;
                clr_big_nxt  = 1'b0;
                clr_lo_nxt   = '0;
              end else begin
                do_fail = 1'b1;
                fail_st = ST_FORMAT;
              end
            end else begin
              if (pos_r == p_wid) begin
                wid_lo_nxt  = hv[DIM_BITS-1:0];
                wid_big_nxt = hv > DIM_MAX;
              end
              if (pos_r == p_hgt) begin
                hgt_lo_nxt  = hv[DIM_BITS-1:0];
                hgt_big_nxt = hv > DIM_MAX;
              end
              if (pos_r == p_bpp) begin
                bpp8_nxt  = (w16 == 16'd8);
                bpp24_nxt = (w16 == 16'd24);
              end
              if (!core_r && pos_r == INFO_COMP) begin
                comp_nz_nxt = (asm_new != 32'd0);
              end
              if (!core_r && pos_r == INFO_CLR) begin
                clr_zero_nxt = (asm_new == 32'd0);
                clr_big_nxt  = asm_new > ENT32;
                clr_lo_nxt   = asm_new[IDX_W-1:0];
              end
              if (pos_r == p_end) begin
                // Depth is checked first, then compression, then size and colors.
                if (!(bpp8_e || bpp24_e)) begin
                  do_fail = 1'b1;
                  fail_st = ST_DEPTH;
                end else if (!core_r && comp_nz_r) begin
                  do_fail = 1'b1;
                  fail_st = ST_PIXELS;
                end else if (wid_big_r || hgt_big_r || colors_over) begin
                  do_fail = 1'b1;
                  fail_st = ST_FORMAT;
                end else begin
                  width_nxt  = wid_lo_r;
                  height_nxt = hgt_lo_r;
                  ccnt_nxt   = colors;
                  if (colors == '0) begin
                    do_sp = 1'b1;
                  end else begin
                    phase_nxt = PH_PAL;
                    pos_nxt   = '0;
                    comp_nxt  = 2'd0;
                  end
                end
              end
            end
          end
          PH_PAL: begin
            if (comp_r >= (core_r ? 2'd2 : 2'd3)) begin
              comp_nxt = 2'd0;
              pos_nxt  = pos_inc;
              if (pos_inc >= ccnt_r) begin
                do_sp = 1'b1;
              end
            end else begin
              comp_nxt = comp_r + 2'd1;
            end
          end
          PH_PIX: begin
            if (bpp8_r) begin
              do_emit = 1'b1;
            end else if (fbc_r < 2'd2) begin
              part_nxt = {b, part_r[15:8]};
              fbc_nxt  = fbc_r + 2'd1;
            end else begin
              fbc_nxt = 2'd0;
              do_emit = 1'b1;
            end
          end
          PH_PAD: begin
            pad_nxt = pad_dec;
            if (pad_dec == 2'd0) begin
              do_end_row = 1'b1;
            end
          end
          PH_AFTER: begin
            phase_nxt = phase_r;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end

      if (do_emit) begin
        push.count = 2'd1;
        push.first = mk_pixel(16'(col_r), 16'(row_r), px_r, px_g, px_b);
        col_nxt    = col_inc[DIM_BITS-1:0];
        if (row_end) begin
          if (pad_new == 2'd0) begin
            do_end_row = 1'b1;
          end else begin
            phase_nxt = PH_PAD;
            pad_nxt   = pad_new;
          end
        end
      end

      if (do_end_row) begin
        if (row_r == '0) begin
          phase_nxt = PH_AFTER;
          if (push.count == 2'd0) begin
            push.first = fin;
          end else begin
            push.second = fin;
          end
          push.count = push.count + 2'd1;
        end else begin
          row_nxt   = row_r - 1'b1;
          col_nxt   = '0;
          phase_nxt = PH_PIX;
        end
      end

      if (do_sp) begin
        if (sp_w == '0 || sp_h == '0) begin
          phase_nxt  = PH_AFTER;
          push.count = 2'd1;
          push.first = fin;
        end else begin
          phase_nxt = PH_PIX;
          row_nxt   = sp_h - 1'b1;
          col_nxt   = '0;
          fbc_nxt   = 2'd0;
        end
      end

      if (do_fail) begin
        phase_nxt  = PH_AFTER;
        push.count = 2'd1;
        push.first = mk_end(KIND_ERROR, fail_st);
      end

      // End of stream always rearms the header reader for the next file.
      if (do_hdr_start) begin
        phase_nxt = PH_HDR;
        pos_nxt   = '0;
        asm_nxt   = '0;
        fbc_nxt   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      phase_r    <= PH_HDR;
      pos_r      <= '0;
      asm_r      <= '0;
      comp_r     <= 2'd0;
      fbc_r      <= 2'd0;
      core_r     <= 1'b0;
      bpp8_r     <= 1'b0;
      bpp24_r    <= 1'b0;
      wid_lo_r   <= '0;
      wid_big_r  <= 1'b0;
      hgt_lo_r   <= '0;
      hgt_big_r  <= 1'b0;
      comp_nz_r  <= 1'b0;
      clr_zero_r <= 1'b1;
      clr_big_r  <= 1'b0;
      clr_lo_r   <= '0;
      width_r    <= '0;
      height_r   <= '0;
      ccnt_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
      pad_r      <= 2'd0;
      part_r     <= '0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      asm_r      <= asm_nxt;
      comp_r     <= comp_nxt;
      fbc_r      <= fbc_nxt;
      core_r     <= core_nxt;
      bpp8_r     <= bpp8_nxt;
      bpp24_r    <= bpp24_nxt;
      wid_lo_r   <= wid_lo_nxt;
      wid_big_r  <= wid_big_nxt;
      hgt_lo_r   <= hgt_lo_nxt;
      hgt_big_r  <= hgt_big_nxt;
      comp_nz_r  <= comp_nz_nxt;
      clr_zero_r <= clr_zero_nxt;
      clr_big_r  <= clr_big_nxt;
      clr_lo_r   <= clr_lo_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      ccnt_r     <= ccnt_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pad_r      <= pad_nxt;
      part_r     <= part_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/bmpd_out_queue.sv */
// Small result queue between the decoder core and the output channel.
// Depends on bmpd_pkg for the result and push types; takes up to two results a cycle.
`default_nettype none

module bmpd_out_queue import bmpd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       space_ok,
  output logic       out_valid,
  input  wire logic  out_stall,
  output result_t    out_data
);

  localparam int QAW = $clog2(OQ_DEPTH);

  result_t        q_r [OQ_DEPTH];
  logic [QAW-1:0] head_r, head_nxt;
  logic [QAW-1:0] tail_r, tail_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic [QAW-1:0] tail_inc;
  logic           pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[head_r];
  assign pop       = out_valid & ~out_stall;
  // Room for the two results a single byte can produce.
  assign space_ok  = cnt_r <= (QAW + 1)'(OQ_DEPTH - 2);
  assign tail_inc  = tail_r + 1'b1;

  assign head_nxt = pop ? (head_r + 1'b1) : head_r;
  assign tail_nxt = tail_r + QAW'(push.count);
  assign cnt_nxt  = cnt_r + (QAW + 1)'(push.count) - (QAW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_r[tail_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      q_r[tail_inc] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/bmp_stream_decoder.sv */
// BMP stream decoder, one file byte per beat, emitting RGB pixels and end-of-file results.
// Instantiates bmpd_parser, bmpd_palette and bmpd_out_queue; uses bmpd_pkg.
//
// The decoder takes one byte (or an end-of-stream marker) per cycle at full rate: each
// byte is captured in an input register, decoded by one pass of logic and its results
// are written to a four-entry output queue, from which they are offered. The rate of one
// byte per cycle is set by the single palette read port, which is read at the accept edge
// of every byte so that an 8-bit pixel finds its color registered when its byte reaches
// decode. Input is stalled only while a byte waits in the input register and the output
// queue lacks room for two results. The palette keeps one valid bit per entry, cleared at
// reset, so no clearing pass is needed and bytes are taken as soon as reset is released.
`default_nettype none

module bmp_stream_decoder import bmpd_pkg::*; #(
  parameter int PALETTE_ENTRIES = PAL_ENTRIES_DFLT,
  parameter int DIM_BITS        = DIM_BITS_DFLT
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output result_t       out_data
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic          accept;
  logic          s0_valid;
  logic          space_ok;
  logic [23:0]   pal_color;
  pal_wr_t       pal_wr;
  logic [AW-1:0] pal_wr_addr;
  push_t         push;

  assign in_stall = s0_valid & ~space_ok;
  assign accept   = in_valid & ~in_stall;

  bmpd_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_byte  (in_data.byte_value),
    .wr       (pal_wr),
    .wr_addr  (pal_wr_addr),
    .rd_color (pal_color)
  );

  bmpd_parser #(
    .ENTRIES  (PALETTE_ENTRIES),
    .DIM_BITS (DIM_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_data     (in_data),
    .space_ok    (space_ok),
    .s0_valid    (s0_valid),
    .pal_color   (pal_color),
    .pal_wr      (pal_wr),
    .pal_wr_addr (pal_wr_addr),
    .push        (push)
  );

  bmpd_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* design/bmpd_checker.sv */
// Port-level checks for the BMP stream decoder, bound to its top level.
// Depends on bmpd_pkg for the result type and codes.
`default_nettype none

module bmpd_checker import bmpd_pkg::*; (
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_stall,
  input wire logic    out_valid,
  input wire logic    out_stall,
  input wire result_t out_data
);

  // A result waiting on a stall stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Input is held back only when results are queued and waiting.
  a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Pixels carry no status; finish and error results carry only status.
  a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_data.result_kind == KIND_PIXEL && out_data.status == ST_OK &&
        !out_data.last_of_file) ||
       ((out_data.result_kind == KIND_FINISH || out_data.result_kind == KIND_ERROR) &&
        out_data.last_of_file && out_data.pixel_x == 16'd0 && out_data.pixel_y == 16'd0 &&
        out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)))
    else $error("malformed result beat");

endmodule

bind bmp_stream_decoder bmpd_checker u_bmpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
